// ----- rtl/rtncs_pkg.sv -----
`timescale 1ns / 1ps
package rtncs_pkg;

  localparam int FACES    = 4;
  localparam int COLS     = FACES + 1;   // matrix columns plus the right-hand side
  localparam int Q_FRAC   = 16;
  localparam int DIV_BITS = 49;          // 33-bit magnitude shifted by Q_FRAC
  localparam int SQRT_BITS = 24;         // root bits of a 47-bit radicand

  localparam logic [2:0] COL_RHS = 3'd4;
  localparam logic [2:0] FC_FULL = 3'd4;

  localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_DIV  = 2'd1,
    OP_SQRT = 2'd2,
    OP_SUB  = 2'd3
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] result;
  } alu_rsp_t;

endpackage

// ----- rtl/rtncs_alu.sv -----
`timescale 1ns / 1ps
module rtncs_alu (
  input  logic                    clk,
  input  logic                    rst,
  input  rtncs_pkg::alu_req_t     req,
  input  logic signed [32:0]      opa,
  input  logic signed [31:0]      opb,
  output rtncs_pkg::alu_rsp_t     rsp
);
  import rtncs_pkg::*;

  logic                      busy;
  alu_op_t                   op_q;
  logic [5:0]                cnt;
  logic [DIV_BITS-1:0]       num;
  logic [32:0]               rem;
  logic [DIV_BITS-1:0]       quo;
  logic [31:0]               dmag;
  logic                      neg;
  logic signed [63:0]        prod;
  logic signed [31:0]        result;
  logic                      done;

  logic [32:0]               amag;
  logic [31:0]               bmag;
  logic signed [32:0]        diff;
  logic signed [31:0]        diff_sat;
  logic [32:0]               dtry;
  logic [32:0]               strial;
  logic [32:0]               stry;
  logic signed [63:0]        prod_adj;
  logic signed [47:0]        prod_sh;
  logic signed [31:0]        mul_sat;
  logic signed [31:0]        div_sat;

  always_comb begin
    amag     = opa[32] ? (~opa + 33'd1) : opa;
    bmag     = opb[31] ? (~opb + 32'd1) : opb;
    diff     = {opa[31], opa[31:0]} - {opb[31], opb};
    if (diff > 33'sh0_7fff_ffff) begin
      diff_sat = S32_MAX;
    end else if (diff < -33'sh0_8000_0000) begin
      diff_sat = S32_MIN;
    end else begin
      diff_sat = diff[31:0];
    end
    dtry     = {rem[31:0], num[DIV_BITS-1]};
    strial   = {7'd0, quo[SQRT_BITS-1:0], 2'b01};
    stry     = {rem[30:0], num[47:46]};
    // truncate toward zero
    prod_adj = prod[63] ? (prod + 64'sd65535) : prod;
    prod_sh  = prod_adj[63:Q_FRAC];
    if (prod_sh > 48'sh0000_7fff_ffff) begin
      mul_sat = S32_MAX;
    end else if (prod_sh < -48'sh0000_8000_0000) begin
      mul_sat = S32_MIN;
    end else begin
      mul_sat = prod_sh[31:0];
    end
    if (neg) begin
      div_sat = (quo > {17'd0, 32'h8000_0000}) ? S32_MIN : (~quo[31:0] + 32'd1);
    end else begin
      div_sat = (quo > {17'd0, 32'h7fff_ffff}) ? S32_MAX : quo[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        op_q <= req.op;
        case (req.op)
          OP_SUB: begin
            result <= diff_sat;
            done   <= 1'b1;
          end
          OP_MUL: begin
            prod <= $signed(opa[31:0]) * opb;
            busy <= 1'b1;
          end
          OP_DIV: begin
            num  <= {amag, {Q_FRAC{1'b0}}};
            dmag <= bmag;
            neg  <= opa[32] ^ opb[31];
            rem  <= '0;
            quo  <= '0;
            cnt  <= 6'(DIV_BITS);
            busy <= 1'b1;
          end
          default: begin
            num  <= {2'b00, opa[30:0], {Q_FRAC{1'b0}}};
            rem  <= '0;
            quo  <= '0;
            cnt  <= 6'(SQRT_BITS);
            busy <= 1'b1;
          end
        endcase
      end else if (busy) begin
        case (op_q)
          OP_MUL: begin
            result <= mul_sat;
            done   <= 1'b1;
            busy   <= 1'b0;
          end
          OP_DIV: begin
            if (cnt != 6'd0) begin
              if (dtry >= {1'b0, dmag}) begin
                rem <= dtry - {1'b0, dmag};
                quo <= {quo[DIV_BITS-2:0], 1'b1};
              end else begin
                rem <= dtry;
                quo <= {quo[DIV_BITS-2:0], 1'b0};
              end
              num <= {num[DIV_BITS-2:0], 1'b0};
              cnt <= cnt - 6'd1;
            end else begin
              result <= div_sat;
              done   <= 1'b1;
              busy   <= 1'b0;
            end
          end
          default: begin
            if (cnt != 6'd0) begin
              if (stry >= strial) begin
                rem <= stry - strial;
                quo <= {quo[DIV_BITS-2:0], 1'b1};
              end else begin
                rem <= stry;
                quo <= {quo[DIV_BITS-2:0], 1'b0};
              end
              num <= {num[DIV_BITS-3:0], 2'b00};
              cnt <= cnt - 6'd1;
            end else begin
              result <= {8'd0, quo[SQRT_BITS-1:0]};
              done   <= 1'b1;
              busy   <= 1'b0;
            end
          end
        endcase
      end
    end
  end

  assign rsp.done   = done;
  assign rsp.result = result;

endmodule

// ----- rtl/rtn_cell_coefficient_solve.sv -----
`timescale 1ns / 1ps
// Face transaction: a square root, two divides and four multiplies, the divides
// skipped when the area is zero, all on the one shared unit.
// The face marked by s_tlast adds the LU solve, dominated by ten divides and cut short
// when a zero pivot ends it; then four result transactions, one per cycle when ready.
// One face at a time: s_tready is high only while the block is idle.
// Synchronous reset clears the sequencer, the face count and the row permutation.
module rtn_cell_coefficient_solve (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // cell_center_y, cell_center_z, cell_area, face_center_y, face_center_z,
  // normal_y, normal_z, face_length, face_flux, 2 zero bits
  input  logic [287:0] s_tdata,
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  // coef_index, coef_value, 6 zero bits
  output logic [39:0]  m_tdata,
  output logic         m_tuser,   // singular
  output logic         m_tlast
);
  import rtncs_pkg::*;

  typedef enum logic [17:0] {
    ST_IDLE   = 18'h00001,
    ST_SQRT   = 18'h00002,
    ST_DIVZ   = 18'h00004,
    ST_DIVY   = 18'h00008,
    ST_MTZ    = 18'h00010,
    ST_MTY    = 18'h00020,
    ST_M0     = 18'h00040,
    ST_M2     = 18'h00080,
    ST_LOAD   = 18'h00100,
    ST_PSRCH  = 18'h00200,
    ST_EDIV   = 18'h00400,
    ST_EMUL   = 18'h00800,
    ST_ESUB   = 18'h01000,
    ST_BSINIT = 18'h02000,
    ST_BSMUL  = 18'h04000,
    ST_BSSUB  = 18'h08000,
    ST_BSDIV  = 18'h10000,
    ST_OUT    = 18'h20000
  } state_t;

  state_t state;
  logic [2:0] fc;
  logic [1:0] perm [FACES];
  logic       issued;

  logic signed [31:0] cy, cz, fy, fz, ny, nz, flux;
  logic [30:0]        area, len;
  logic               last;
  logic signed [31:0] h, cz1, cy1, tz, ty, lq, mq, sq, pv;
  logic [31:0]        best;
  logic [1:0]         p;
  logic signed [31:0] st [FACES][COLS];
  logic signed [31:0] w  [FACES][COLS];
  logic signed [31:0] x  [FACES];
  logic               singular;
  logic [1:0]         k, i, oi;
  logic [2:0]         j;

  alu_req_t           req;
  alu_rsp_t           rsp;
  logic signed [32:0] opa;
  logic signed [31:0] opb;
  logic               op_state;
  logic [1:0]         rr;
  logic [2:0]         rc;
  logic signed [31:0] rd;
  logic [31:0]        rmag;
  logic               upd;
  logic [31:0]        best_n;
  logic [1:0]         p_n;
  logic signed [31:0] pv_n;
  logic [1:0]         row;

  rtncs_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (req),
    .opa (opa),
    .opb (opb),
    .rsp (rsp)
  );

  assign row = (fc >= FC_FULL) ? 2'd3 : fc[1:0];

  always_comb begin
    rr = i;
    rc = {1'b0, k};
    case (state)
      ST_EMUL:   begin rr = k; rc = j;              end
      ST_ESUB:   begin rr = i; rc = j;              end
      ST_BSINIT: begin rr = i; rc = COL_RHS;        end
      ST_BSMUL:  begin rr = i; rc = j;              end
      ST_BSDIV:  begin rr = i; rc = {1'b0, i};      end
      default:   begin rr = i; rc = {1'b0, k};      end
    endcase
    rd     = w[perm[rr]][rc];
    rmag   = rd[31] ? (~rd + 32'd1) : rd;
    upd    = (i == k) || (rmag > best);
    best_n = upd ? rmag : best;
    p_n    = upd ? i : p;
    pv_n   = upd ? rd : pv;
  end

  always_comb begin
    op_state = 1'b1;
    req.op   = OP_MUL;
    opa      = {tz[31], tz};
    opb      = cz1;
    case (state)
      ST_SQRT:  begin req.op = OP_SQRT; opa = {2'b00, area}; opb = '0;          end
      ST_DIVZ:  begin req.op = OP_DIV;  opa = {fz[31], fz} - {cz[31], cz}; opb = h; end
      ST_DIVY:  begin req.op = OP_DIV;  opa = {fy[31], fy} - {cy[31], cy}; opb = h; end
      ST_MTZ:   begin req.op = OP_MUL;  opa = {2'b00, len}; opb = nz;           end
      ST_MTY:   begin req.op = OP_MUL;  opa = {2'b00, len}; opb = ny;           end
      ST_M0:    begin req.op = OP_MUL;  opa = {tz[31], tz}; opb = cz1;          end
      ST_M2:    begin req.op = OP_MUL;  opa = {ty[31], ty}; opb = cy1;          end
      ST_EDIV:  begin req.op = OP_DIV;  opa = {rd[31], rd}; opb = pv;           end
      ST_EMUL:  begin req.op = OP_MUL;  opa = {lq[31], lq}; opb = rd;           end
      ST_ESUB:  begin req.op = OP_SUB;  opa = {rd[31], rd}; opb = mq;           end
      ST_BSMUL: begin req.op = OP_MUL;  opa = {rd[31], rd}; opb = x[j[1:0]];    end
      ST_BSSUB: begin req.op = OP_SUB;  opa = {sq[31], sq}; opb = mq;           end
      ST_BSDIV: begin req.op = OP_DIV;  opa = {sq[31], sq}; opb = rd;           end
      default:  op_state = 1'b0;
    endcase
    req.start = op_state && !issued;
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      fc     <= '0;
      issued <= 1'b0;
      for (int n = 0; n < FACES; n++) begin
        perm[n] <= 2'(n);
      end
    end else begin
      if (req.start) begin
        issued <= 1'b1;
      end else if (rsp.done) begin
        issued <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (rsp.done) begin
            state <= (rsp.result == 32'sd0) ? ST_MTZ : ST_DIVZ;
          end
        end
        ST_DIVZ: if (rsp.done) state <= ST_DIVY;
        ST_DIVY: if (rsp.done) state <= ST_MTZ;
        ST_MTZ:  if (rsp.done) state <= ST_MTY;
        ST_MTY:  if (rsp.done) state <= ST_M0;
        ST_M0:   if (rsp.done) state <= ST_M2;
        ST_M2: begin
          if (rsp.done) begin
            if (fc < FC_FULL) begin
              fc <= fc + 3'd1;
            end
            state <= last ? ST_LOAD : ST_IDLE;
          end
        end
        ST_LOAD: begin
          fc <= '0;
          for (int n = 0; n < FACES; n++) begin
            perm[n] <= 2'(n);
          end
          state <= ST_PSRCH;
        end
        ST_PSRCH: begin
          if (i == 2'd3) begin
            if (best_n == 32'd0) begin
              state <= ST_OUT;
            end else begin
              perm[k]   <= perm[p_n];
              perm[p_n] <= perm[k];
              state     <= (k == 2'd3) ? ST_BSINIT : ST_EDIV;
            end
          end
        end
        ST_EDIV: if (rsp.done) state <= ST_EMUL;
        ST_EMUL: if (rsp.done) state <= ST_ESUB;
        ST_ESUB: begin
          if (rsp.done && j == COL_RHS) begin
            state <= (i == 2'd3) ? ST_PSRCH : ST_EDIV;
          end else if (rsp.done) begin
            state <= ST_EMUL;
          end
        end
        ST_BSINIT: state <= (i == 2'd3) ? ST_BSDIV : ST_BSMUL;
        ST_BSMUL:  if (rsp.done) state <= ST_BSSUB;
        ST_BSSUB: begin
          if (rsp.done) begin
            state <= (j == 3'd3) ? ST_BSDIV : ST_BSMUL;
          end
        end
        ST_BSDIV: begin
          if (rsp.done) begin
            state <= (i == 2'd0) ? ST_OUT : ST_BSINIT;
          end
        end
        ST_OUT: begin
          if (m_tready && oi == 2'd3) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cy   <= s_tdata[31:0];
          cz   <= s_tdata[63:32];
          area <= s_tdata[94:64];
          fy   <= s_tdata[126:95];
          fz   <= s_tdata[158:127];
          ny   <= s_tdata[190:159];
          nz   <= s_tdata[222:191];
          len  <= s_tdata[253:223];
          flux <= s_tdata[285:254];
          last <= s_tlast;
        end
      end
      ST_SQRT: begin
        if (rsp.done) begin
          h   <= rsp.result;
          cz1 <= '0;
          cy1 <= '0;
        end
      end
      ST_DIVZ: if (rsp.done) cz1 <= rsp.result;
      ST_DIVY: if (rsp.done) cy1 <= rsp.result;
      ST_MTZ:  if (rsp.done) tz <= rsp.result;
      ST_MTY:  if (rsp.done) ty <= rsp.result;
      ST_M0: begin
        if (rsp.done) begin
          st[row][0] <= rsp.result;
          st[row][1] <= tz;
        end
      end
      ST_M2: begin
        if (rsp.done) begin
          st[row][2] <= rsp.result;
          st[row][3] <= ty;
          st[row][4] <= flux;
        end
      end
      ST_LOAD: begin
        w        <= st;
        singular <= 1'b0;
        k        <= '0;
        i        <= '0;
        oi       <= '0;
      end
      ST_PSRCH: begin
        best <= best_n;
        p    <= p_n;
        pv   <= pv_n;
        if (i == 2'd3) begin
          if (best_n == 32'd0) begin
            singular <= 1'b1;
          end else begin
            i <= (k == 2'd3) ? 2'd3 : k + 2'd1;
          end
        end else begin
          i <= i + 2'd1;
        end
      end
      ST_EDIV: begin
        if (rsp.done) begin
          lq <= rsp.result;
          j  <= {1'b0, k} + 3'd1;
        end
      end
      ST_EMUL: if (rsp.done) mq <= rsp.result;
      ST_ESUB: begin
        if (rsp.done) begin
          w[perm[i]][j] <= rsp.result;
          if (j == COL_RHS) begin
            if (i == 2'd3) begin
              k <= k + 2'd1;
              i <= k + 2'd1;   // next search starts at the new pivot row
            end else begin
              i <= i + 2'd1;
            end
          end else begin
            j <= j + 3'd1;
          end
        end
      end
      ST_BSINIT: begin
        sq <= rd;
        j  <= {1'b0, i} + 3'd1;
      end
      ST_BSMUL: if (rsp.done) mq <= rsp.result;
      ST_BSSUB: begin
        if (rsp.done) begin
          sq <= rsp.result;
          j  <= j + 3'd1;
        end
      end
      ST_BSDIV: begin
        if (rsp.done) begin
          x[i] <= rsp.result;
          if (i != 2'd0) begin
            i <= i - 2'd1;
          end
        end
      end
      ST_OUT: begin
        if (m_tready) begin
          oi <= oi + 2'd1;
        end
      end
      default: ;
    endcase
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_OUT);
  assign m_tdata  = {6'd0, (singular ? 32'sd0 : x[oi]), oi};
  assign m_tuser  = singular;
  assign m_tlast  = (oi == 2'd3);

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input taken while results pending");

  a_ready_after_cell: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> s_tready)
    else $error("block not idle after last coefficient");

  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[33:2] == 32'd0))
    else $error("singular cell with nonzero coefficient");

  a_face_count: assert property (@(posedge clk) disable iff (rst)
    fc <= FC_FULL)
    else $error("face count out of range");

endmodule
